>>> rtl/core/fsts_pkg.sv
// Shared types, widths, register codes and reset values for the fixed-step tick scheduler.
package fsts_pkg;

    localparam int ELAPSED_W   = 64;
    localparam int OBS_W       = 63;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 8;
    localparam int ALPHA_W     = 16;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_W       = TIME_W + 1;
    localparam int PROD_W      = CNT_W + TIME_W;
    localparam int DIV_STEPS   = ACC_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 216;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UPD   = 2'd2;

    localparam logic [TIME_W-1:0] RST_STEP_LEN  = 32'd16666667;
    localparam logic [TIME_W-1:0] RST_MAX_FRAME = 32'd250000000;
    localparam logic [CNT_W-1:0]  RST_MAX_UPD   = 8'd5;

    localparam logic [OBS_W-1:0] OBS_MAX = {OBS_W{1'b1}};

    // Classified item as handed from front to back
    typedef struct packed {
        logic              clear;
        logic [OBS_W-1:0]  observed;
        logic [TIME_W-1:0] sim;
        logic [OBS_W-1:0]  dropped;
    } t_work;

    typedef struct packed {
        logic [OBS_W-1:0]   observed;
        logic [TIME_W-1:0]  sim;
        logic [OBS_W-1:0]   dropped;
        logic [CNT_W-1:0]   count;
        logic [TIME_W-1:0]  remainder;
        logic [ALPHA_W-1:0] alpha;
        logic               clamped;
    } t_result;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DIV,
        BS_MUL,
        BS_BACKLOG,
        BS_DROP,
        BS_DONE
    } t_bstate;

endpackage

>>> rtl/core/fsts_front.sv
// Front end: input handshake, sign handling and frame-time clamp.
module fsts_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [fsts_pkg::ELAPSED_W-1:0] i_elapsed,
    input  logic [fsts_pkg::TIME_W-1:0]    i_max_frame,
    input  logic                          i_full,
    output logic                          o_push,
    output fsts_pkg::t_work               o_work
);

    logic [fsts_pkg::OBS_W-1:0]  w_observed;
    logic [fsts_pkg::OBS_W-1:0]  w_limit;
    logic [fsts_pkg::TIME_W-1:0] w_sim;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Force negative times to zero, then clamp to the frame limit
    assign w_observed = i_elapsed[fsts_pkg::ELAPSED_W-1] ? '0
                                                         : i_elapsed[fsts_pkg::OBS_W-1:0];
    assign w_limit    = {{(fsts_pkg::OBS_W-fsts_pkg::TIME_W){1'b0}}, i_max_frame};
    assign w_sim      = (w_observed > w_limit) ? i_max_frame
                                               : w_observed[fsts_pkg::TIME_W-1:0];

    always_comb begin
        o_work = '0;
        if (i_req_type) begin
            o_work.clear = 1'b1;
        end else begin
            o_work.observed = w_observed;
            o_work.sim      = w_sim;
            o_work.dropped  = w_observed
                            - {{(fsts_pkg::OBS_W-fsts_pkg::TIME_W){1'b0}}, w_sim};
        end
    end

endmodule

>>> rtl/core/fsts_queue.sv
// Short FIFO of classified items between front and back.
module fsts_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fsts_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output fsts_pkg::t_work o_work,
    output logic            o_empty
);

    fsts_pkg::t_work                r_mem [fsts_pkg::QUEUE_DEPTH];
    logic [fsts_pkg::QPTR_W-1:0]    r_wptr;
    logic [fsts_pkg::QPTR_W-1:0]    r_rptr;
    logic [fsts_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == fsts_pkg::QCNT_W'(fsts_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/fsts_div.sv
// Restoring serial divider: integer quotient and remainder, then fraction bits.
module fsts_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [fsts_pkg::ACC_W-1:0]      i_dividend,
    input  logic [fsts_pkg::TIME_W-1:0]     i_divisor,
    output logic                            o_done,
    output logic [fsts_pkg::DIV_STEPS-1:0]  o_quot,
    output logic [fsts_pkg::TIME_W-1:0]     o_rem
);

    logic                            r_busy;
    logic                            r_done;
    logic [fsts_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [fsts_pkg::DIV_STEPS-1:0]  r_num;
    logic [fsts_pkg::DIV_STEPS-1:0]  r_quot;
    logic [fsts_pkg::TIME_W-1:0]     r_rem;
    logic [fsts_pkg::TIME_W-1:0]     r_rem_int;
    logic [fsts_pkg::TIME_W-1:0]     r_divisor;

    logic [fsts_pkg::TIME_W:0]       w_shifted;
    logic [fsts_pkg::TIME_W:0]       w_diff;
    logic                            w_ge;
    logic [fsts_pkg::TIME_W-1:0]     w_rem;
    logic                            w_last;

    // Remainder stays below the divisor, so the shifted value fits one extra bit
    assign w_shifted = {r_rem, r_num[fsts_pkg::DIV_STEPS-1]};
    assign w_diff    = w_shifted - {1'b0, r_divisor};
    assign w_ge      = (w_shifted >= {1'b0, r_divisor});
    assign w_rem     = w_ge ? w_diff[fsts_pkg::TIME_W-1:0] : w_shifted[fsts_pkg::TIME_W-1:0];
    assign w_last    = (r_cnt == fsts_pkg::DIV_CNT_W'(fsts_pkg::DIV_STEPS - 1));

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num     <= {i_dividend, {fsts_pkg::FRAC_BITS{1'b0}}};
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_num  <= {r_num[fsts_pkg::DIV_STEPS-2:0], 1'b0};
            r_quot <= {r_quot[fsts_pkg::DIV_STEPS-2:0], w_ge};
            r_rem  <= w_rem;
            // Hold the remainder of the integer part before fraction bits start
            if (r_cnt == fsts_pkg::DIV_CNT_W'(fsts_pkg::ACC_W - 1)) begin
                r_rem_int <= w_rem;
            end
        end
    end

endmodule

>>> rtl/core/fsts_back.sv
// Back end: accumulator, step count, backlog drop and result register.
module fsts_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fsts_pkg::t_work                 i_work,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  logic [fsts_pkg::TIME_W-1:0]     i_step_len,
    input  logic [fsts_pkg::CNT_W-1:0]      i_max_upd,
    output logic                            o_div_start,
    output logic [fsts_pkg::ACC_W-1:0]      o_div_dividend,
    output logic [fsts_pkg::TIME_W-1:0]     o_div_divisor,
    input  logic                            i_div_done,
    input  logic [fsts_pkg::DIV_STEPS-1:0]  i_div_quot,
    input  logic [fsts_pkg::TIME_W-1:0]     i_div_rem,
    output logic                            o_valid,
    input  logic                            i_ready,
    output fsts_pkg::t_result               o_result
);

    fsts_pkg::t_bstate              r_state;
    fsts_pkg::t_bstate              n_state;
    logic [fsts_pkg::TIME_W-1:0]    r_acc;
    fsts_pkg::t_work                r_item;
    logic [fsts_pkg::ACC_W-1:0]     r_sum;
    logic [fsts_pkg::CNT_W-1:0]     r_count;
    logic [fsts_pkg::PROD_W-1:0]    r_prod;
    logic [fsts_pkg::ACC_W-1:0]     r_backlog;
    fsts_pkg::t_result              r_res;
    fsts_pkg::t_result              r_out;
    logic                           r_out_valid;

    logic [fsts_pkg::TIME_W-1:0]    w_step;
    logic [fsts_pkg::ACC_W-1:0]     w_sum;
    logic [fsts_pkg::ACC_W-1:0]     w_qint;
    logic [fsts_pkg::OBS_W:0]       w_drop_sum;
    logic [fsts_pkg::OBS_W-1:0]     w_dropped;
    logic                           w_out_free;
    logic                           w_load_out;

    assign w_step     = (i_step_len == '0) ? fsts_pkg::TIME_W'(1) : i_step_len;
    assign w_sum      = {1'b0, r_acc} + {1'b0, i_work.sim};
    assign w_qint     = i_div_quot[fsts_pkg::DIV_STEPS-1:fsts_pkg::FRAC_BITS];
    assign w_drop_sum = {1'b0, r_item.dropped}
                      + {{(fsts_pkg::OBS_W+1-fsts_pkg::ACC_W){1'b0}}, r_backlog};
    assign w_dropped  = w_drop_sum[fsts_pkg::OBS_W] ? fsts_pkg::OBS_MAX
                                                    : w_drop_sum[fsts_pkg::OBS_W-1:0];
    assign w_out_free = !r_out_valid || i_ready;

    assign o_div_dividend = w_sum;
    assign o_div_divisor  = w_step;
    assign o_valid        = r_out_valid;
    assign o_result       = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsts_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    n_state = i_work.clear ? fsts_pkg::BS_DONE : fsts_pkg::BS_DIV;
                end
            end
            fsts_pkg::BS_DIV: begin
                if (i_div_done) begin
                    n_state = fsts_pkg::BS_MUL;
                end
            end
            fsts_pkg::BS_MUL:     n_state = fsts_pkg::BS_BACKLOG;
            fsts_pkg::BS_BACKLOG: n_state = fsts_pkg::BS_DROP;
            fsts_pkg::BS_DROP:    n_state = fsts_pkg::BS_DONE;
            fsts_pkg::BS_DONE: begin
                if (w_out_free) begin
                    n_state = fsts_pkg::BS_IDLE;
                end
            end
            default: n_state = fsts_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == fsts_pkg::BS_IDLE) && !i_empty;
        o_div_start = o_pop && !i_work.clear;
        w_load_out  = (r_state == fsts_pkg::BS_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsts_pkg::BS_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_work.clear) begin
                r_acc <= '0;
            end else if ((r_state == fsts_pkg::BS_DIV) && i_div_done) begin
                r_acc <= i_div_rem;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fsts_pkg::BS_IDLE: begin
                if (o_pop) begin
                    r_item <= i_work;
                    r_sum  <= w_sum;
                    if (i_work.clear) begin
                        r_res <= '0;
                    end
                end
            end
            fsts_pkg::BS_DIV: begin
                if (i_div_done) begin
                    // Cap the step count at the update limit
                    r_count <= (w_qint < fsts_pkg::ACC_W'(i_max_upd))
                             ? w_qint[fsts_pkg::CNT_W-1:0] : i_max_upd;
                    r_res.remainder <= i_div_rem;
                    r_res.alpha     <= fsts_pkg::ALPHA_W'(i_div_quot[fsts_pkg::FRAC_BITS-1:0]);
                end
            end
            fsts_pkg::BS_MUL: begin
                r_prod <= {{fsts_pkg::TIME_W{1'b0}}, r_count}
                        * {{fsts_pkg::CNT_W{1'b0}}, w_step};
            end
            fsts_pkg::BS_BACKLOG: begin
                // Time of the whole steps left over after the issued ones
                r_backlog <= r_sum - {1'b0, r_acc} - r_prod[fsts_pkg::ACC_W-1:0];
            end
            fsts_pkg::BS_DROP: begin
                r_res.observed <= r_item.observed;
                r_res.sim      <= r_item.sim;
                r_res.dropped  <= w_dropped;
                r_res.count    <= r_count;
                r_res.clamped  <= (w_dropped != '0);
            end
            fsts_pkg::BS_DONE: begin
                if (w_load_out) begin
                    r_out <= r_res;
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

endmodule

>>> rtl/core/fixed_step_tick_scheduler.sv
// A frame item runs through a start, the 49-step serial divider (33 integer quotient bits
// plus 16 fraction bits) and the multiply, backlog, drop and hand-off states; a clear item
// skips the divider. The back end finishes one item before it takes the next.
// A two-entry queue takes new items while the back end works or a result waits.
// Reset (synchronous, active low) clears the accumulator and loads the register defaults.
module fixed_step_tick_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fsts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fsts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [63:0] elapsed
    input  logic                             s_axis_tuser,  // [0] req_type
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [62:0] observed, [94:63] simulated, [157:95] dropped, [165:158] step count,
    // [197:166] remainder, [213:198] fraction, [214] clamped flag, [215] zero
    output logic [fsts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [fsts_pkg::TIME_W-1:0]     r_step_len;
    logic [fsts_pkg::TIME_W-1:0]     r_max_frame;
    logic [fsts_pkg::CNT_W-1:0]      r_max_upd;

    logic                            w_push;
    logic                            w_full;
    logic                            w_empty;
    logic                            w_pop;
    fsts_pkg::t_work                 w_front_work;
    fsts_pkg::t_work                 w_queue_work;
    logic                            w_div_start;
    logic [fsts_pkg::ACC_W-1:0]      w_div_dividend;
    logic [fsts_pkg::TIME_W-1:0]     w_div_divisor;
    logic                            w_div_done;
    logic [fsts_pkg::DIV_STEPS-1:0]  w_div_quot;
    logic [fsts_pkg::TIME_W-1:0]     w_div_rem;
    fsts_pkg::t_result               w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_len  <= fsts_pkg::RST_STEP_LEN;
            r_max_frame <= fsts_pkg::RST_MAX_FRAME;
            r_max_upd   <= fsts_pkg::RST_MAX_UPD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fsts_pkg::CFG_STEP_LEN:  r_step_len  <= i_cfg_data[fsts_pkg::TIME_W-1:0];
                fsts_pkg::CFG_MAX_FRAME: r_max_frame <= i_cfg_data[fsts_pkg::TIME_W-1:0];
                fsts_pkg::CFG_MAX_UPD:   r_max_upd   <= i_cfg_data[fsts_pkg::CNT_W-1:0];
                default: begin
                    r_step_len <= r_step_len;
                end
            endcase
        end
    end

    fsts_front u_front (
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req_type  (s_axis_tuser),
        .i_elapsed   (s_axis_tdata),
        .i_max_frame (r_max_frame),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_work      (w_front_work)
    );

    fsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_work  (w_queue_work),
        .o_empty (w_empty)
    );

    fsts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    fsts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_work         (w_queue_work),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .i_step_len     (r_step_len),
        .i_max_upd      (r_max_upd),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .o_div_divisor  (w_div_divisor),
        .i_div_done     (w_div_done),
        .i_div_quot     (w_div_quot),
        .i_div_rem      (w_div_rem),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_result       (w_result)
    );

    assign m_axis_tdata = {1'b0,
                           w_result.clamped,
                           w_result.alpha,
                           w_result.remainder,
                           w_result.count,
                           w_result.dropped,
                           w_result.sim,
                           w_result.observed};

endmodule
